// ----- design/ptts_pkg.sv -----
package ptts_pkg;

    // Default table size
    localparam int SLOT_COUNT_DEF = 16;

    // Field widths fixed by the interface
    localparam int CMD_W    = 2;
    localparam int PERIOD_W = 16;
    localparam int TIDX_W   = 4;
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int TICK_W   = 64;

    // First slot handed out by a create
    localparam int FIRST_FREE = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_CREATE = 2'd1,
        CMD_REPORT = 2'd2
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        K_FIRED     = 3'd0,
        K_CREATED   = 3'd1,
        K_FULL      = 3'd2,
        K_TICK_END  = 3'd3,
        K_END_NOTED = 3'd4
    } t_kind;

    // One result beat
    typedef struct packed {
        t_kind               kind;
        logic [SLOT_W-1:0]   slot;
        logic [TICK_W-1:0]   tick_count;
        logic                last;
    } t_res;

    // Verdict of the countdown unit for one slot
    typedef struct packed {
        logic                fire;
        logic                wr;
        logic [PERIOD_W-1:0] count;
    } t_eval;

endpackage

// ----- design/ptts_unit.sv -----
module ptts_unit (
    input  logic                              i_run,
    input  logic [ptts_pkg::PERIOD_W-1:0]     i_period,
    input  logic [ptts_pkg::PERIOD_W-1:0]     i_count,
    output ptts_pkg::t_eval                   o_eval
);

    logic w_live;
    logic w_zero;

    // Only a running slot with a nonzero period takes part
    assign w_live = i_run && (i_period != '0);
    assign w_zero = (i_count == '0);

    // Fire and reload on zero, otherwise count down
    always_comb begin
        o_eval.fire  = w_live && w_zero;
        o_eval.wr    = w_live;
        o_eval.count = w_zero ? i_period : (i_count - ptts_pkg::PERIOD_W'(1));
    end

endmodule

// ----- design/ptts_store.sv -----
module ptts_store #(
    parameter int SLOT_COUNT = ptts_pkg::SLOT_COUNT_DEF,
    parameter int IW         = $clog2(SLOT_COUNT)
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [IW-1:0]                 i_rd_addr,
    output logic [ptts_pkg::PERIOD_W-1:0] o_rd_period,
    output logic [ptts_pkg::PERIOD_W-1:0] o_rd_count,
    input  logic                          i_per_we,
    input  logic [IW-1:0]                 i_per_addr,
    input  logic [ptts_pkg::PERIOD_W-1:0] i_per_data,
    input  logic                          i_cnt_we,
    input  logic [IW-1:0]                 i_cnt_addr,
    input  logic [ptts_pkg::PERIOD_W-1:0] i_cnt_data
);

    logic [ptts_pkg::PERIOD_W-1:0] r_per_mem [SLOT_COUNT];
    logic [ptts_pkg::PERIOD_W-1:0] r_cnt_mem [SLOT_COUNT];
    logic [ptts_pkg::PERIOD_W-1:0] r_per_q;
    logic [ptts_pkg::PERIOD_W-1:0] r_cnt_q;

    // Write ports
    always_ff @(posedge i_clk) begin
        if (i_per_we) begin
            r_per_mem[i_per_addr] <= i_per_data;
        end
        if (i_cnt_we) begin
            r_cnt_mem[i_cnt_addr] <= i_cnt_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_per_q <= r_per_mem[i_rd_addr];
            r_cnt_q <= r_cnt_mem[i_rd_addr];
        end
    end

    assign o_rd_period = r_per_q;
    assign o_rd_count  = r_cnt_q;

endmodule

// ----- design/ptts_obuf.sv -----
module ptts_obuf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  ptts_pkg::t_res                i_res,
    output logic                          o_free,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ptts_pkg::KIND_W-1:0]   o_kind,
    output logic [ptts_pkg::SLOT_W-1:0]   o_slot,
    output logic [ptts_pkg::TICK_W-1:0]   o_tick_count,
    output logic                          o_last
);

    logic           r_vld;
    logic           n_vld;
    ptts_pkg::t_res r_res;

    // Room for a new beat when empty or the current one leaves now
    assign o_free = !r_vld || !i_out_stall;

    always_comb begin
        n_vld = r_vld;
        if (i_load) begin
            n_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Hold payload until a new beat is loaded
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid  = r_vld;
    assign o_kind       = r_res.kind;
    assign o_slot       = r_res.slot;
    assign o_tick_count = r_res.tick_count;
    assign o_last       = r_res.last;

endmodule

// ----- design/periodic_task_tick_scheduler.sv -----
// Create and report items are accepted, then give one result beat.
// A tick walks the table, reading one slot per cycle while not paused,
// through the slot store and the shared countdown unit, then a tick end beat.
// A stall on the result side pauses the walk at the next firing slot.
// Synchronous active-low reset clears run flags and tick count and sets the
// next free slot to FIRST_FREE; period and countdown stores need no clearing.
module periodic_task_tick_scheduler #(
    parameter int SLOT_COUNT = ptts_pkg::SLOT_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ptts_pkg::CMD_W-1:0]      i_cmd,
    input  logic [ptts_pkg::PERIOD_W-1:0]   i_period,
    input  logic [ptts_pkg::TIDX_W-1:0]     i_task_index,
    input  logic                            i_stop,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ptts_pkg::KIND_W-1:0]     o_kind,
    output logic [ptts_pkg::SLOT_W-1:0]     o_slot,
    output logic [ptts_pkg::TICK_W-1:0]     o_tick_count,
    output logic                            o_last
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_TEND,
        S_SINGLE
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_rd_idx, n_rd_idx;
    logic                            r_ev_vld, n_ev_vld;
    logic [IW-1:0]                   r_ev_idx, n_ev_idx;
    logic [IW-1:0]                   r_next_free, n_next_free;
    logic [ptts_pkg::TICK_W-1:0]     r_ticks, n_ticks;
    logic [SLOT_COUNT-1:0]           r_run, n_run;
    ptts_pkg::t_res                  r_pend, n_pend;

    logic                            w_in_acc;
    logic                            w_out_free;
    logic                            w_load;
    ptts_pkg::t_res                  w_load_res;
    logic                            w_full;
    logic [IW-1:0]                   w_rep_idx;
    logic                            w_rep_ok;
    logic                            w_rd_done;
    logic                            w_adv;
    logic                            w_rd_en;
    logic [ptts_pkg::PERIOD_W-1:0]   w_rd_period;
    logic [ptts_pkg::PERIOD_W-1:0]   w_rd_count;
    logic                            w_per_we;
    logic                            w_cnt_we;
    logic [IW-1:0]                   w_cnt_addr;
    logic [ptts_pkg::PERIOD_W-1:0]   w_cnt_data;
    ptts_pkg::t_eval                 w_eval;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_full    = (r_next_free >= IW'(SLOT_COUNT - 1));
    assign w_rep_idx = IW'(i_task_index);
    assign w_rep_ok  = (int'(i_task_index) < SLOT_COUNT);
    assign w_rd_done = (r_rd_idx == CW'(SLOT_COUNT));

    // Advance the walk unless a firing slot finds the result register busy
    assign w_adv   = (r_state == S_WALK) && !(r_ev_vld && w_eval.fire && !w_out_free);
    assign w_rd_en = w_adv && !w_rd_done;

    ptts_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .IW         (IW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rd_en     (w_rd_en),
        .i_rd_addr   (r_rd_idx[IW-1:0]),
        .o_rd_period (w_rd_period),
        .o_rd_count  (w_rd_count),
        .i_per_we    (w_per_we),
        .i_per_addr  (r_next_free),
        .i_per_data  (i_period),
        .i_cnt_we    (w_cnt_we),
        .i_cnt_addr  (w_cnt_addr),
        .i_cnt_data  (w_cnt_data)
    );

    ptts_unit u_unit (
        .i_run    (r_run[r_ev_idx]),
        .i_period (w_rd_period),
        .i_count  (w_rd_count),
        .o_eval   (w_eval)
    );

    ptts_obuf u_obuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_res        (w_load_res),
        .o_free       (w_out_free),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_slot       (o_slot),
        .o_tick_count (o_tick_count),
        .o_last       (o_last)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_ev_vld    = r_ev_vld;
        n_ev_idx    = r_ev_idx;
        n_next_free = r_next_free;
        n_ticks     = r_ticks;
        n_run       = r_run;
        n_pend      = r_pend;

        w_load                = 1'b0;
        w_load_res.kind       = ptts_pkg::K_FIRED;
        w_load_res.slot       = ptts_pkg::SLOT_W'(r_ev_idx);
        w_load_res.tick_count = '0;
        w_load_res.last       = 1'b0;

        w_per_we   = 1'b0;
        w_cnt_we   = 1'b0;
        w_cnt_addr = r_ev_idx;
        w_cnt_data = w_eval.count;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_cmd)
                        ptts_pkg::CMD_TICK: begin
                            n_ticks  = r_ticks + ptts_pkg::TICK_W'(1);
                            n_rd_idx = '0;
                            n_ev_vld = 1'b0;
                            n_state  = S_WALK;
                        end
                        ptts_pkg::CMD_CREATE: begin
                            n_pend.tick_count = '0;
                            n_pend.last       = 1'b1;
                            if (w_full) begin
                                n_pend.kind = ptts_pkg::K_FULL;
                                n_pend.slot = '0;
                            end else begin
                                // Claim the slot; its countdown starts at zero
                                w_per_we           = 1'b1;
                                w_cnt_we           = 1'b1;
                                w_cnt_addr         = r_next_free;
                                w_cnt_data         = '0;
                                n_run[r_next_free] = 1'b1;
                                n_next_free        = r_next_free + IW'(1);
                                n_pend.kind        = ptts_pkg::K_CREATED;
                                n_pend.slot        = ptts_pkg::SLOT_W'(r_next_free);
                            end
                            n_state = S_SINGLE;
                        end
                        ptts_pkg::CMD_REPORT: begin
                            if (w_rep_ok && i_stop) begin
                                n_run[w_rep_idx] = 1'b0;
                            end
                            n_pend.kind       = ptts_pkg::K_END_NOTED;
                            n_pend.slot       = i_task_index;
                            n_pend.tick_count = '0;
                            n_pend.last       = 1'b1;
                            n_state           = S_SINGLE;
                        end
                        default: begin
                            // unused command: drop without a result
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (w_adv) begin
                    // Retire the slot held in the read register
                    if (r_ev_vld) begin
                        w_cnt_we = w_eval.wr;
                        w_load   = w_eval.fire;
                    end
                    // Issue the next read
                    n_ev_vld = !w_rd_done;
                    n_ev_idx = r_rd_idx[IW-1:0];
                    if (w_rd_done) begin
                        n_state = S_TEND;
                    end else begin
                        n_rd_idx = r_rd_idx + CW'(1);
                    end
                end
            end
            S_TEND: begin
                if (w_out_free) begin
                    w_load                = 1'b1;
                    w_load_res.kind       = ptts_pkg::K_TICK_END;
                    w_load_res.slot       = '0;
                    w_load_res.tick_count = r_ticks;
                    w_load_res.last       = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            S_SINGLE: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    w_load_res = r_pend;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_idx    <= '0;
            r_ev_vld    <= 1'b0;
            r_next_free <= IW'(ptts_pkg::FIRST_FREE);
            r_ticks     <= '0;
            r_run       <= '0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_ev_vld    <= n_ev_vld;
            r_next_free <= n_next_free;
            r_ticks     <= n_ticks;
            r_run       <= n_run;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_ev_idx <= n_ev_idx;
        r_pend   <= n_pend;
    end

`ifndef ASSERT_OFF
    a_next_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= IW'(SLOT_COUNT - 1))
        else $error("next free slot beyond table");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result loaded into a busy register");

    a_walk_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_rd_idx <= CW'(SLOT_COUNT)))
        else $error("walk index beyond table");

    a_tick_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_cmd == ptts_pkg::CMD_TICK))
        |=> (r_ticks == $past(r_ticks) + ptts_pkg::TICK_W'(1)))
        else $error("tick count not advanced by one");

    a_fire_needs_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_load_res.kind == ptts_pkg::K_FIRED))
        |-> ((r_state == S_WALK) && r_ev_vld))
        else $error("fired result outside the walk");
`endif

endmodule
